// File: rtl/core/dcor_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dcor_pkg;

  localparam int unsigned SUM_W   = 32;
  localparam int unsigned SMP_W   = 16;
  localparam int unsigned LEN_W   = 15;
  localparam int unsigned IDX_W   = 14;
  localparam int unsigned CFG_AW  = 3;
  localparam int unsigned CFG_DW  = 32;

  localparam logic [LEN_W-1:0] LEN_RST = 15'd16384;
  localparam logic [SMP_W-1:0] MIN_RST = 16'hFFFF;

  // register index, taken from paddr[2]
  localparam logic REG_BLOCK_LENGTH = 1'b0;

  localparam logic [1:0] FN_PUSH = 2'd0;
  localparam logic [1:0] FN_READ = 2'd1;
  localparam logic [1:0] FN_NEW  = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_BAD_READ = 2'd2;

  typedef struct packed {
    logic [1:0]       func;
    logic [31:0]      raw_word;
    logic [IDX_W-1:0] read_index;
  } in_item_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] conditioned_sample;
    logic                    block_complete;
    logic [1:0]              status;
  } out_item_t;

endpackage

`default_nettype wire

// File: rtl/core/dcor_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module dcor_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16384,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    addr,
  input  wire logic [WIDTH-1:0] wdata,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// File: rtl/core/dcor_div.sv
`timescale 1ns / 1ps
`default_nettype none

module dcor_div
  import dcor_pkg::*;
#(
  parameter int unsigned CW = 15
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [SUM_W-1:0] dividend,
  input  wire logic [CW-1:0]    divisor,
  output logic                  done,
  output logic [SUM_W-1:0]      quotient
);

  localparam int unsigned STEP_W = $clog2(SUM_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [SUM_W-1:0]  dvd_r, dvd_nxt;
  logic [SUM_W-1:0]  quo_r, quo_nxt;
  logic [CW-1:0]     rem_r, rem_nxt;
  logic [CW-1:0]     dsr_r, dsr_nxt;
  logic [CW:0]       trial;
  logic              fits;

  assign trial = {rem_r, dvd_r[SUM_W-1]};
  assign fits  = trial >= {1'b0, dsr_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    dvd_nxt  = dvd_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      dvd_nxt  = dividend;
      rem_nxt  = '0;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[SUM_W-2:0], 1'b0};
      quo_nxt = {quo_r[SUM_W-2:0], fits};
      rem_nxt = fits ? CW'(trial - {1'b0, dsr_r}) : trial[CW-1:0];
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(SUM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    dvd_r <= dvd_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

// File: rtl/core/dcor_apb.sv
`timescale 1ns / 1ps
`default_nettype none

module dcor_apb
  import dcor_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic      [CFG_DW-1:0] prdata,
  output logic                   pready,
  output logic      [LEN_W-1:0]  block_length
);

  logic [LEN_W-1:0] len_r, len_nxt;
  logic             wr_len;

  assign pready = 1'b1;
  assign wr_len = psel && penable && pwrite && (paddr[2] == REG_BLOCK_LENGTH);

  always_comb begin
    len_nxt = len_r;
    if (wr_len) begin
      len_nxt = pwdata[LEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= LEN_RST;
    end else begin
      len_r <= len_nxt;
    end
  end

  assign prdata       = (paddr[2] == REG_BLOCK_LENGTH) ? CFG_DW'(len_r) : '0;
  assign block_length = len_r;

endmodule

`default_nettype wire

// File: rtl/core/block_dc_offset_removal_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// channel | dir | handshake         | payload
// in      | in  | in_valid/in_ready | in_data (in_item_t)
// out     | out | out_valid/out_ready | out_data (out_item_t)
// cfg     | in  | psel/penable/pready | paddr, pwdata, prdata
//
// Push, new block, unused codes: done in idle. Read: adds S_READ (registered RAM read).
// Push that fills the block: S_MUL, S_LOAD, S_DIV (32 divider shift steps, then done).
// Reset is synchronous; the sample RAM is not cleared, no sweep after reset.
// A result waiting on out_ready stalls the next item only at its finishing cycle.

module block_dc_offset_removal_unit
  import dcor_pkg::*;
#(
  parameter int unsigned BLOCK_DEPTH = 16384
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire in_item_t          in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output out_item_t              out_data,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic      [CFG_DW-1:0] prdata,
  output logic                   pready
);

  localparam int unsigned CW = $clog2(BLOCK_DEPTH + 1);
  localparam int unsigned AW = (BLOCK_DEPTH > 1) ? $clog2(BLOCK_DEPTH) : 1;
  localparam int unsigned XW = CW + 18;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_LOAD = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_EMIT = 3'd5;

  logic [2:0]       state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic [SMP_W-1:0] min_r, min_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [SMP_W-1:0] mean_r, mean_nxt;
  logic             done_r, done_nxt;
  logic [SUM_W-1:0] prod_r;
  out_item_t        out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        pend_r, pend_nxt;

  logic [LEN_W-1:0] block_length;
  logic [CW-1:0]    len_use;
  logic             accept;
  logic             out_free;
  logic             fin;
  out_item_t        fin_item;
  logic [SMP_W-1:0] sample;
  logic             push_ok;
  logic             read_ok;
  logic [CW-1:0]    count_inc;
  logic             ram_we;
  logic [AW-1:0]    ram_addr;
  logic [SMP_W-1:0] ram_rdata;
  logic             div_start;
  logic             div_done;
  logic [SUM_W-1:0] div_quo;
  logic [CW+15:0]   prod_full;

  dcor_apb u_apb (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .block_length (block_length)
  );

  always_comb begin
    if (XW'(block_length) > XW'(BLOCK_DEPTH)) begin
      len_use = CW'(BLOCK_DEPTH);
    end else if (block_length == '0) begin
      len_use = CW'(1);
    end else begin
      len_use = CW'(block_length);
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign sample    = in_data.raw_word[SMP_W+1:2];
  assign push_ok   = !done_r && (count_r < len_use);
  assign read_ok   = done_r && (XW'(in_data.read_index) < XW'(count_r));
  assign count_inc = count_r + 1'b1;
  assign prod_full = count_r * min_r;

  assign ram_we   = accept && (in_data.func == FN_PUSH) && push_ok;
  assign ram_addr = (in_data.func == FN_PUSH) ? AW'(count_r) : AW'(in_data.read_index);

  dcor_ram #(
    .WIDTH (SMP_W),
    .DEPTH (BLOCK_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (sample),
    .rdata (ram_rdata)
  );

  dcor_div #(
    .CW (CW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r - prod_r),
    .divisor  (count_r),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign div_start = (state_r == S_LOAD);

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    min_nxt   = min_r;
    sum_nxt   = sum_r;
    mean_nxt  = mean_r;
    done_nxt  = done_r;
    fin       = 1'b0;
    fin_item  = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_data.func)
            FN_PUSH: begin
              if (push_ok) begin
                count_nxt = count_inc;
                min_nxt   = (sample < min_r) ? sample : min_r;
                sum_nxt   = sum_r + SUM_W'(sample);
                if (count_inc == len_use) begin
                  state_nxt = S_MUL;
                end else begin
                  fin = 1'b1;
                end
              end else begin
                fin             = 1'b1;
                fin_item.status = ST_FULL;
              end
            end
            FN_READ: begin
              if (read_ok) begin
                state_nxt = S_READ;
              end else begin
                fin             = 1'b1;
                fin_item.status = ST_BAD_READ;
              end
            end
            FN_NEW: begin
              count_nxt = '0;
              min_nxt   = MIN_RST;
              sum_nxt   = '0;
              mean_nxt  = '0;
              done_nxt  = 1'b0;
              fin       = 1'b1;
            end
            default: begin
              fin = 1'b1;
            end
          endcase
          fin_item.block_complete = done_nxt;
        end
      end
      S_READ: begin
        fin                         = 1'b1;
        fin_item.conditioned_sample = ram_rdata - min_r - mean_r;
        fin_item.block_complete     = done_r;
        fin_item.status             = ST_OK;
      end
      S_MUL: begin
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          mean_nxt                = div_quo[SMP_W-1:0];
          done_nxt                = 1'b1;
          fin                     = 1'b1;
          fin_item.block_complete = 1'b1;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (fin) begin
      state_nxt = out_free ? S_IDLE : S_EMIT;
    end
  end

  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    pend_nxt      = pend_r;
    if (fin) begin
      if (out_free) begin
        out_nxt       = fin_item;
        out_valid_nxt = 1'b1;
      end else begin
        pend_nxt = fin_item;
      end
    end else if ((state_r == S_EMIT) && out_free) begin
      out_nxt       = pend_r;
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      min_r       <= MIN_RST;
      sum_r       <= '0;
      mean_r      <= '0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      min_r       <= min_nxt;
      sum_r       <= sum_nxt;
      mean_r      <= mean_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
    prod_r <= SUM_W'(prod_full);
    out_r  <= out_nxt;
    pend_r <= pend_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// File: rtl/core/dcor_chk.sv
`timescale 1ns / 1ps
`default_nettype none

module dcor_chk
  import dcor_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire in_item_t          in_data,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire out_item_t         out_data,
  input wire logic              psel,
  input wire logic              penable,
  input wire logic              pwrite,
  input wire logic [CFG_AW-1:0] paddr,
  input wire logic [CFG_DW-1:0] pwdata,
  input wire logic [CFG_DW-1:0] prdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != ST_OK) |-> out_data.conditioned_sample == '0)
    else $error("error result carries nonzero sample");

  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.func == FN_READ) && out_data.block_complete
      && out_valid |=> !in_ready || !out_data.block_complete || out_valid)
    else $error("read did not occupy the RAM read cycle");

  a_cfg_rb: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable && pwrite && (paddr[2] == REG_BLOCK_LENGTH)
      |=> paddr[2] != REG_BLOCK_LENGTH
          || prdata == CFG_DW'($past(pwdata[LEN_W-1:0])))
    else $error("block_length readback mismatch");

  a_new_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.func == FN_NEW) && !out_valid
      |=> out_valid && !out_data.block_complete && (out_data.status == ST_OK))
    else $error("new block result wrong");

endmodule

bind block_dc_offset_removal_unit dcor_chk u_dcor_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data),
  .psel      (psel),
  .penable   (penable),
  .pwrite    (pwrite),
  .paddr     (paddr),
  .pwdata    (pwdata),
  .prdata    (prdata)
);

`default_nettype wire
